// ----- design/pqct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqct_pkg: shared types and constants of the quad crossing test
// corner table sizing, point type, function codes and cell control bundle
// ----------------------------------------------------------------------------
package pqct_pkg;

    localparam int CHANNELS = 8;
    localparam int CORNERS  = 4;
    localparam int COORD_W  = 16;
    localparam int CHAN_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // width of the edge differences and of their products
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TEST = 1'b1
    } t_func;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic              en;
        logic              wr;
        logic [CHAN_W-1:0] addr;
    } t_cell_ctl;

endpackage

// ----- design/pqct_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqct_cell: one corner cell of the crossing ring
// stores one corner of every channel and tests the edge from its neighbour
// ----------------------------------------------------------------------------
module pqct_cell (
    input  logic               i_clk,
    input  pqct_pkg::t_cell_ctl i_ctl,
    input  pqct_pkg::t_point   i_wdata,
    input  pqct_pkg::t_point   i_hit,
    input  pqct_pkg::t_point   i_prev,
    output pqct_pkg::t_point   o_corner,
    input  logic               i_par,
    output logic               o_par
);
    import pqct_pkg::*;

    t_point r_mem [CHANNELS];
    t_point r_corner;

    logic signed [DIFF_W-1:0] n_dhy;
    logic signed [DIFF_W-1:0] n_dxb;
    logic signed [DIFF_W-1:0] n_dhx;
    logic signed [DIFF_W-1:0] n_dy;
    logic signed [PROD_W-1:0] n_lhs;
    logic signed [PROD_W-1:0] n_rhs;
    logic                     n_cnt;
    logic signed [PROD_W-1:0] r_lhs;
    logic signed [PROD_W-1:0] r_rhs;
    logic                     r_cnt;
    logic                     r_dy_pos;
    logic                     n_left;

    // corner store, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_ctl.addr] <= i_wdata;
        end
        if (i_ctl.en) begin
            r_corner <= r_mem[i_ctl.addr];
        end
    end

    assign o_corner = r_corner;

    // edge from neighbour corner (b) to own corner (a)
    always_comb begin
        n_dhy = $signed({i_hit.y[COORD_W-1], i_hit.y})
              - $signed({r_corner.y[COORD_W-1], r_corner.y});
        n_dxb = $signed({i_prev.x[COORD_W-1], i_prev.x})
              - $signed({r_corner.x[COORD_W-1], r_corner.x});
        n_dhx = $signed({i_hit.x[COORD_W-1], i_hit.x})
              - $signed({r_corner.x[COORD_W-1], r_corner.x});
        n_dy  = $signed({i_prev.y[COORD_W-1], i_prev.y})
              - $signed({r_corner.y[COORD_W-1], r_corner.y});
        n_lhs = n_dhy * n_dxb;
        n_rhs = n_dhx * n_dy;
        n_cnt = ((r_corner.y < i_hit.y) && (i_prev.y >= i_hit.y)
                 || (i_prev.y < i_hit.y) && (r_corner.y >= i_hit.y))
                && ((r_corner.x <= i_hit.x) || (i_prev.x <= i_hit.x));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_lhs    <= n_lhs;
            r_rhs    <= n_rhs;
            r_cnt    <= n_cnt;
            r_dy_pos <= (n_dy > $signed({DIFF_W{1'b0}}));
        end
    end

    // crossing strictly left of the hit, sign of edge height folded in
    assign n_left = r_dy_pos ? (r_lhs < r_rhs) : (r_lhs > r_rhs);
    assign o_par  = i_par ^ (r_cnt && n_left);

endmodule

// ----- design/point_in_quad_crossing_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_quad_crossing_test: even-odd point in quadrilateral test
// four corner cells in a ring, one per corner, each testing one edge
// ----------------------------------------------------------------------------
// a test transaction passes corner read, cross products, and compare and parity
//   chain in that order before its result is registered at the output
// throughput: one transaction per cycle while the result side takes results;
//   a held result freezes all three stages
// reset: clears the stage valids; the corner tables are undefined until loaded
// a load transaction writes one corner and gives no result
module point_in_quad_crossing_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [2:0]  i_channel,
    input  logic [1:0]  i_corner,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_inside_res,
    output logic [2:0]  o_tested_channel
);
    import pqct_pkg::*;

    logic        n_en;
    logic        n_accept;
    logic        n_ch_ok;
    t_point      n_in_pt;
    t_cell_ctl   n_ctl [CORNERS];
    t_point      w_corner [CORNERS];
    logic        w_par [CORNERS+1];
    logic        n_inside;

    // stage 1: corners being read, hit point alongside
    logic        r_v1;
    logic        r_ok1;
    logic [2:0]  r_ch1;
    t_point      r_hit1;
    // stage 2: products registered inside the cells
    logic        r_v2;
    logic        r_ok2;
    logic [2:0]  r_ch2;
    // output register
    logic        r_ov;
    logic        r_inside;
    logic [2:0]  r_och;

    // whole pipe advances unless a result is held by the far side
    assign n_en     = !(r_ov && i_stall);
    assign o_stall  = !n_en;
    assign n_accept = i_valid && n_en;
    assign n_ch_ok  = (32'(i_channel) < CHANNELS);
    assign n_in_pt  = '{x: i_coord_x, y: i_coord_y};

    // cell k holds corner k; its edge starts at corner k-1 (ring)
    for (genvar k = 0; k < CORNERS; k++) begin : g_cell
        always_comb begin
            n_ctl[k].en   = n_en;
            n_ctl[k].wr   = n_accept && (i_func == FUNC_LOAD) && n_ch_ok
                            && (32'(i_corner) == k);
            n_ctl[k].addr = CHAN_W'(i_channel);
        end

        pqct_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (n_ctl[k]),
            .i_wdata  (n_in_pt),
            .i_hit    (r_hit1),
            .i_prev   (w_corner[(k + CORNERS - 1) % CORNERS]),
            .o_corner (w_corner[k]),
            .i_par    (w_par[k]),
            .o_par    (w_par[k+1])
        );
    end

    // parity passes cell to cell, starting even
    assign w_par[0] = 1'b0;
    // an out of range channel is never inside
    assign n_inside = r_ok2 && w_par[CORNERS];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (n_en) begin
            r_v1 <= n_accept && (i_func == FUNC_TEST);
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    // payload of the stages
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ok1    <= n_ch_ok;
            r_ch1    <= i_channel;
            r_hit1   <= n_in_pt;
            r_ok2    <= r_ok1;
            r_ch2    <= r_ch1;
            r_inside <= n_inside;
            r_och    <= r_ch2;
        end
    end

    assign o_valid          = r_ov;
    assign o_inside_res     = r_inside;
    assign o_tested_channel = r_och;

endmodule

// ----- design/pqct_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqct_checker: port level checks of the quad crossing test
// result hold, stall source and fixed latency of test transactions
// ----------------------------------------------------------------------------
module pqct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_func,
    input logic [2:0]  i_channel,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_inside_res,
    input logic [2:0]  o_tested_channel
);
    import pqct_pkg::*;

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_inside_res)
                               && $stable(o_tested_channel))
        else $error("held result changed");

    // input side stalls only behind a held result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stalled without a held result");

    // with the pipe moving, each test and nothing else gives a result, carrying its channel
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
        && !$past(o_stall, 1) && !$past(o_stall, 2) && !$past(o_stall, 3)
        |-> (o_valid == $past(i_valid && (i_func == FUNC_TEST), 3))
            && (!o_valid || (o_tested_channel == $past(i_channel, 3))))
        else $error("test result out of place");

endmodule

bind point_in_quad_crossing_test pqct_checker u_pqct_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_func           (i_func),
    .i_channel        (i_channel),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_inside_res     (o_inside_res),
    .o_tested_channel (o_tested_channel)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_in_quad_crossing_test
// loads corner quads per channel and fires hit tests at them; an in-bench
// even-odd crossing predictor follows every accepted transaction and each
// result is compared in order against the oldest predicted verdict
// ----------------------------------------------------------------------------
module tb;
    import pqct_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake on either side
    localparam int ITEM_TARGET = 1050;
    localparam int DRAIN_AT    = 400;    // forced drain-and-resume somewhere in the middle

    // one pending input transaction; drain_first holds it back until all
    // outstanding results have been taken
    typedef struct {
        t_func             func;
        logic [CHAN_W-1:0] channel;
        logic [1:0]        corner;
        t_point            pt;
        bit                drain_first;
    } t_stim_item;

    typedef struct {
        logic              in_quad;
        logic [CHAN_W-1:0] channel;
    } t_verdict;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              i_func     = 1'b0;
    logic [2:0]        i_channel  = '0;
    logic [1:0]        i_corner   = '0;
    logic signed [15:0] i_coord_x = '0;
    logic signed [15:0] i_coord_y = '0;
    logic              i_stall    = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_inside_res;
    logic [2:0]        o_tested_channel;

    t_stim_item pending_items[$];
    t_verdict   expected_verdicts[$];

    // predictor copy of the corner store
    t_point quad_corners[CHANNELS*CORNERS];

    // stimulus-side copy, used only to aim hits and to avoid unloaded corners
    t_point          planned_corners[CHANNELS*CORNERS];
    bit [CORNERS-1:0] loaded_mask[CHANNELS];

    int n_items     = 0;
    int items_taken = 0;
    int mismatches  = 0;
    int quiet_cycles = 0;

    point_in_quad_crossing_test i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_channel        (i_channel),
        .i_corner         (i_corner),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_inside_res     (o_inside_res),
        .o_tested_channel (o_tested_channel)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor: even-odd crossing over edges 3-0, 0-1, 1-2, 2-3
    // ------------------------------------------------------------------
    function automatic logic point_inside_quad(int unsigned chan, t_point hit);
        longint hx, hy, xa, ya, xb, yb, dy, lhs, rhs;
        int unsigned base, prev;
        logic odd;
        bit straddles, left_end, crosses;
        base = chan * CORNERS;
        prev = CORNERS - 1;
        odd  = 1'b0;
        hx   = $signed(hit.x);
        hy   = $signed(hit.y);
        for (int cur = 0; cur < CORNERS; cur++) begin
            xa = $signed(quad_corners[base + cur].x);
            ya = $signed(quad_corners[base + cur].y);
            xb = $signed(quad_corners[base + prev].x);
            yb = $signed(quad_corners[base + prev].y);
            // one end strictly below, the other at or above; flat edges never pass
            straddles = (ya < hy && yb >= hy) || (yb < hy && ya >= hy);
            left_end  = (xa <= hx) || (xb <= hx);
            if (straddles && left_end) begin
                dy  = yb - ya;
                lhs = (hy - ya) * (xb - xa);
                rhs = (hx - xa) * dy;
                // exact form of x_cross < hx, flipping the compare for a falling edge
                crosses = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                if (crosses)
                    odd = ~odd;
            end
            prev = cur;
        end
        return odd;
    endfunction

    // idle share in percent: sender light / receiver heavy, then swapped, then none
    function automatic int idle_pct(bit sender_side);
        if (items_taken < 350)
            return sender_side ? 11 : 56;
        else if (items_taken < 700)
            return sender_side ? 56 : 11;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_item(t_func func, int chan, int corner, t_point pt, bit drain);
        t_stim_item it;
        it.func        = func;
        it.channel     = chan[CHAN_W-1:0];
        it.corner      = corner[1:0];
        it.pt          = pt;
        it.drain_first = drain;
        pending_items.push_back(it);
        n_items++;
    endfunction

    function automatic void load_corner(int chan, int corner, int x, int y);
        t_point p;
        p.x = x[15:0];
        p.y = y[15:0];
        planned_corners[chan*CORNERS + corner] = p;
        loaded_mask[chan][corner] = 1'b1;
        push_item(FUNC_LOAD, chan, corner, p, 1'b0);
    endfunction

    function automatic void test_at(int chan, int x, int y, bit drain);
        t_point p;
        p.x = x[15:0];
        p.y = y[15:0];
        // corner field is don't-care on a test, so let it wander
        push_item(FUNC_TEST, chan, $urandom_range(0, 3), p, drain);
    endfunction

    // tight ranges give many shared y values and flat edges
    function automatic int rand_coord(int scale);
        case (scale)
            0:       return int'($urandom_range(0, 16)) - 8;
            1:       return int'($urandom_range(0, 4000)) - 2000;
            default: return int'($signed($urandom() & 32'hFFFF) <<< 16) >>> 16;
        endcase
    endfunction

    // aim a hit at a fully loaded channel: inside its box, on a corner,
    // on an edge midpoint, level with a corner, or anywhere
    function automatic void test_aimed(int chan, bit drain);
        int base, xmin, xmax, ymin, ymax, a, b, xa, ya, xb, yb, cx, cy;
        base = chan * CORNERS;
        xmin = 32767;  xmax = -32768;
        ymin = 32767;  ymax = -32768;
        for (int k = 0; k < CORNERS; k++) begin
            cx = $signed(planned_corners[base + k].x);
            cy = $signed(planned_corners[base + k].y);
            if (cx < xmin) xmin = cx;
            if (cx > xmax) xmax = cx;
            if (cy < ymin) ymin = cy;
            if (cy > ymax) ymax = cy;
        end
        a  = $urandom_range(0, CORNERS - 1);
        b  = (a + 1) % CORNERS;
        xa = $signed(planned_corners[base + a].x);
        ya = $signed(planned_corners[base + a].y);
        xb = $signed(planned_corners[base + b].x);
        yb = $signed(planned_corners[base + b].y);
        case ($urandom_range(0, 5))
            0, 1: test_at(chan, xmin + int'($urandom_range(0, xmax - xmin)),
                          ymin + int'($urandom_range(0, ymax - ymin)), drain);
            2:    test_at(chan, xa, ya, drain);
            3:    test_at(chan, (xa + xb) / 2, (ya + yb) / 2, drain);
            4:    test_at(chan, xmin + int'($urandom_range(0, xmax - xmin)), ya, drain);
            default: test_at(chan, rand_coord(2), rand_coord(2), drain);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: presents the next pending transaction once the bus is free
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stim_item nxt;
        bit launch;
        launch = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid)
                items_taken <= items_taken + 1;
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                // a drain transaction waits for an idle bus and no result outstanding
                launch = !pending_items[0].drain_first ||
                         (!i_valid && expected_verdicts.size() == 0);
            end
            if (launch) begin
                nxt = pending_items.pop_front();
                i_func    <= nxt.func;
                i_channel <= nxt.channel;
                i_corner  <= nxt.corner;
                i_coord_x <= nxt.pt.x;
                i_coord_y <= nxt.pt.y;
            end
            i_valid <= launch;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts from accepted inputs, checks accepted results,
    // and drives the result-side stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_point   pt;
        t_verdict v;
        t_verdict want;
        int       bad;
        bad = 0;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            // prediction first, so a same-cycle result would still find its verdict
            if (i_valid && !o_stall) begin
                pt.x = i_coord_x;
                pt.y = i_coord_y;
                if (t_func'(i_func) == FUNC_LOAD) begin
                    if (i_channel < CHANNELS)
                        quad_corners[i_channel*CORNERS + i_corner] = pt;
                end else begin
                    v.in_quad = (i_channel < CHANNELS) && point_inside_quad(i_channel, pt);
                    v.channel = i_channel;
                    expected_verdicts.push_back(v);
                end
            end
            if (o_valid && !i_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result transaction: inside_res %0b tested_channel %0d",
                           o_inside_res, o_tested_channel);
                    bad++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_inside_res !== want.in_quad) begin
                        $error("inside_res expected %0b got %0b", want.in_quad, o_inside_res);
                        bad++;
                    end
                    if (o_tested_channel !== want.channel) begin
                        $error("tested_channel expected %0d got %0d",
                               want.channel, o_tested_channel);
                        bad++;
                    end
                end
            end
            if (bad != 0)
                mismatches <= mismatches + bad;
            i_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
        end
    end

    // watchdog: too long without any handshake means the block has hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("point_in_quad_crossing_test: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int pick, chan, scale, start;
        bit drained_once;
        drained_once = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
            loaded_mask[c] = '0;

        // axis-aligned square, with hits inside, outside and on every side
        load_corner(0, 0, -100, -100);
        load_corner(0, 1,  100, -100);
        load_corner(0, 2,  100,  100);
        load_corner(0, 3, -100,  100);
        test_at(0,    0,    0, 1'b0);
        test_at(0,  200,    0, 1'b0);
        test_at(0,  100,    0, 1'b0);
        test_at(0, -100,    0, 1'b0);
        test_at(0,    0, -100, 1'b0);
        test_at(0,    0,  100, 1'b0);

        // full-range quad on the top channel, hits at the coordinate extremes
        load_corner(7, 0, -32768, -32768);
        load_corner(7, 1,  32767, -32768);
        load_corner(7, 2,  32767,  32767);
        load_corner(7, 3, -32768,  32767);
        test_at(7,      0,      0, 1'b0);
        test_at(7, -32768, -32768, 1'b0);
        test_at(7,  32767,  32767, 1'b0);
        test_at(7, -32768,      0, 1'b0);

        // collapsed quad: every edge is flat, so nothing can ever be counted
        for (int k = 0; k < CORNERS; k++)
            load_corner(1, k, 5, 5);
        test_at(1, 5, 5, 1'b0);

        // random part: mostly full quad loads followed by aimed hits
        while (n_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                chan  = $urandom_range(0, CHANNELS - 1);
                scale = $urandom_range(0, 2);
                start = $urandom_range(0, CORNERS - 1);
                for (int k = 0; k < CORNERS; k++)
                    load_corner(chan, (start + k) % CORNERS, rand_coord(scale), rand_coord(scale));
                repeat ($urandom_range(2, 6))
                    test_aimed(chan, 1'b0);
            end else if (pick < 90) begin
                // only channels with all corners loaded may be tested
                do
                    chan = $urandom_range(0, CHANNELS - 1);
                while (loaded_mask[chan] != '1);
                test_aimed(chan, pick >= 86 || (!drained_once && n_items >= DRAIN_AT));
                if (n_items >= DRAIN_AT)
                    drained_once = 1'b1;
            end else begin
                // stray single-corner rewrite
                load_corner($urandom_range(0, CHANNELS - 1), $urandom_range(0, CORNERS - 1),
                            rand_coord(2), rand_coord(2));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        // wait on so any stray extra result gets caught
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("point_in_quad_crossing_test: match");
        else
            $display("point_in_quad_crossing_test: mismatch");
        $finish;
    end

endmodule
